>>> rtl/gtp_pkg.sv
// Shared types, constants and the arctangent table of the go-to-pose controller.
`default_nettype none
package gtp_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int DELTA_W  = 33;
   localparam int CORDIC_W = 52;
   localparam int ANGLE_W  = 28;
   localparam int ATAN_IDX_W = 5;

   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic [29:0]  INV_GAIN_Q30 = 30'd652032874;
   localparam logic signed [17:0] PI_Q13     = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
   localparam logic [13:0]  LIN_MAX = 14'd8192;
   localparam logic signed [15:0] ANG_MAX = 16'sd16384;

   localparam logic [15:0] DISTANCE_GAIN_RST      = 16'd2048;
   localparam logic [15:0] HEADING_GAIN_RST       = 16'd6144;
   localparam logic [31:0] DISTANCE_TOLERANCE_RST = 32'd6554;
   localparam logic [14:0] HEADING_TOLERANCE_RST  = 15'd410;

   typedef enum logic [2:0] {
      REG_TARGET_X           = 3'd0,
      REG_TARGET_Y           = 3'd1,
      REG_TARGET_HEADING     = 3'd2,
      REG_DISTANCE_GAIN      = 3'd3,
      REG_HEADING_GAIN       = 3'd4,
      REG_DISTANCE_TOLERANCE = 3'd5,
      REG_HEADING_TOLERANCE  = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_RUNNING   = 2'd0,
      STATUS_SUCCEEDED = 2'd1,
      STATUS_CANCELED  = 2'd2
   } goal_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MDIST,
      ST_DIST,
      ST_ERR,
      ST_LIN,
      ST_ANG,
      ST_OUT
   } state_type;

   // Rounded atan(2^-i) in units of 2^-24 rad.
   function automatic logic signed [ANGLE_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         5'd0:  val = 28'sd13176795;
         5'd1:  val = 28'sd7778716;
         5'd2:  val = 28'sd4110060;
         5'd3:  val = 28'sd2086331;
         5'd4:  val = 28'sd1047214;
         5'd5:  val = 28'sd524117;
         5'd6:  val = 28'sd262123;
         5'd7:  val = 28'sd131069;
         5'd8:  val = 28'sd65536;
         5'd9:  val = 28'sd32768;
         5'd10: val = 28'sd16384;
         5'd11: val = 28'sd8192;
         5'd12: val = 28'sd4096;
         5'd13: val = 28'sd2048;
         5'd14: val = 28'sd1024;
         5'd15: val = 28'sd512;
         5'd16: val = 28'sd256;
         5'd17: val = 28'sd128;
         5'd18: val = 28'sd64;
         5'd19: val = 28'sd32;
         5'd20: val = 28'sd16;
         5'd21: val = 28'sd8;
         5'd22: val = 28'sd4;
         5'd23: val = 28'sd2;
         5'd24: val = 28'sd1;
         default: val = 28'sd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

>>> rtl/go_to_pose_p_controller.sv
// Top level of the go-to-pose proportional controller.
//
// The req channel carries one pose beat per control tick; the rsp channel returns at most
// one velocity command beat for it. The csr channel writes the goal point, goal heading,
// gains and tolerances by register index and is always ready; the user must write it
// only while idle, as the block itself does not enforce this. A beat with start_goal
// arms a new goal and returns nothing. While no goal is armed, beats return nothing.
// A cancel skips the CORDIC pass and returns a zero command with status canceled.
// A beat without a valid pose returns nothing. A valid pose runs one vectoring CORDIC
// pass, then the states ST_MDIST, ST_DIST, ST_ERR, ST_LIN and ST_ANG, which pass the
// distance scale, the linear and the angular terms through one shared multiplier.
// req_tready is low while a pose is in work, so a new pose beat is taken only once the
// command of the last one has been moved to the output register.
// The command sits in an output register; if the receiver stalls, the next beat is
// still accepted, and its result waits until that register is taken.
// Reset restores the register defaults, clears the goal and drops rsp_tvalid.
`default_nettype none
module go_to_pose_p_controller #(
   parameter int CORDIC_ITERATIONS = gtp_pkg::CORDIC_ITERATIONS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // pose_x, pose_y, pose_yaw
   input  wire logic [2:0]  req_tuser,   // pose_valid, cancel_request, start_goal
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // linear_velocity, angular_velocity,
                                         // distance_feedback, zero fill
   output logic [1:0]       rsp_tuser,   // goal_status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import gtp_pkg::*;

   state_type state_ff, state_in;

   logic signed [31:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic signed [15:0] target_heading_ff, target_heading_in;
   logic [15:0]        distance_gain_ff, distance_gain_in, heading_gain_ff, heading_gain_in;
   logic [31:0]        distance_tolerance_ff, distance_tolerance_in;
   logic [14:0]        heading_tolerance_ff, heading_tolerance_in;

   logic goal_active_ff, goal_active_in, position_reached_ff, position_reached_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] yaw_ff, yaw_in;
   logic               zero_ff, zero_in;
   logic [31:0]        dist_ff, dist_in;
   logic signed [16:0] err_ff, err_in;
   logic [13:0]        lin_ff, lin_in;
   logic signed [67:0] prod_ff, prod_in;

   logic [13:0]        res_lin_ff, res_lin_in;
   logic signed [15:0] res_ang_ff, res_ang_in;
   logic [31:0]        res_dist_ff, res_dist_in;
   goal_status_type    res_status_ff, res_status_in;

   logic [13:0]        out_lin_ff, out_lin_in;
   logic signed [15:0] out_ang_ff, out_ang_in;
   logic [31:0]        out_dist_ff, out_dist_in;
   goal_status_type    out_status_ff, out_status_in;

   logic signed [31:0] pose_x, pose_y;
   logic signed [15:0] pose_yaw;
   logic               pose_valid, cancel_request, start_goal;
   logic               req_accept, out_free, cordic_start, cordic_done;
   logic signed [DELTA_W-1:0]  delta_x, delta_y;
   logic signed [CORDIC_W-1:0] cordic_x;
   logic signed [ANGLE_W-1:0]  cordic_z;

   logic [CORDIC_W-1:0]        x_clip;
   logic [CORDIC_W:0]          m_sum;
   logic signed [35:0]         mul_a;
   logic signed [31:0]         mul_b;
   logic signed [67:0]         dist_sum, lin_sum, ang_sum;
   logic [53:0]                lin_q;
   logic signed [56:0]         ang_q;
   logic signed [15:0]         ang_val;
   logic signed [ANGLE_W-1:0]  z_round;
   logic signed [16:0]         head_q13, heading_sel;
   logic signed [17:0]         err_raw;
   logic [16:0]                err_abs;

   assign pose_x         = req_tdata[31:0];
   assign pose_y         = req_tdata[63:32];
   assign pose_yaw       = req_tdata[79:64];
   assign pose_valid     = req_tuser[0];
   assign cancel_request = req_tuser[1];
   assign start_goal     = req_tuser[2];

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign delta_x    = {target_x_ff[31], target_x_ff} - {pose_x[31], pose_x};
   assign delta_y    = {target_y_ff[31], target_y_ff} - {pose_y[31], pose_y};

   gtp_cordic #(
      .ITERATIONS(CORDIC_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .delta_x (delta_x),
      .delta_y (delta_y),
      .done    (cordic_done),
      .x_out   (cordic_x),
      .z_out   (cordic_z)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !start_goal && goal_active_ff) begin
               if (cancel_request) begin
                  state_in = ST_OUT;
               end else if (pose_valid) begin
                  state_in = ST_CORDIC;
               end
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               state_in = ST_MDIST;
            end
         end
         ST_MDIST: state_in = ST_DIST;
         ST_DIST:  state_in = ST_ERR;
         ST_ERR:   state_in = ST_LIN;
         ST_LIN:   state_in = ST_ANG;
         ST_ANG:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cordic_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cordic_start = req_tvalid && !start_goal && goal_active_ff && !cancel_request
                           && pose_valid;
         end
         default: begin
            req_tready   = 1'b0;
            cordic_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      x_clip = (cordic_x < 0) ? '0 : cordic_x;
      m_sum  = {1'b0, x_clip} + (CORDIC_W+1)'(32768);
      case (state_ff)
         ST_MDIST: begin
            mul_a = {1'b0, m_sum[50:16]};
            mul_b = {2'b00, INV_GAIN_Q30};
         end
         ST_ERR: begin
            mul_a = {4'd0, dist_ff};
            mul_b = {16'd0, distance_gain_ff};
         end
         ST_LIN: begin
            mul_a = {{19{err_ff[16]}}, err_ff};
            mul_b = {16'd0, heading_gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      dist_sum = prod_ff + 68'sd536870912;
      lin_sum  = prod_ff + 68'sd8192;
      ang_sum  = prod_ff + 68'sd1024;
      lin_q    = lin_sum[67:14];
      ang_q    = ang_sum[67:11];
      if (ang_q > 57'sd16384) begin
         ang_val = ANG_MAX;
      end else if (ang_q < -57'sd16384) begin
         ang_val = -ANG_MAX;
      end else begin
         ang_val = ang_q[15:0];
      end
      z_round     = cordic_z + ANGLE_W'(1024);
      head_q13    = zero_ff ? '0 : z_round[ANGLE_W-1:11];
      heading_sel = position_reached_ff ? {target_heading_ff[15], target_heading_ff}
                                        : head_q13;
      err_raw     = {heading_sel[16], heading_sel} - {{2{yaw_ff[15]}}, yaw_ff};
      err_abs     = (err_ff < 0) ? 17'(-err_ff) : 17'(err_ff);
   end

   always_comb begin
      target_x_in           = target_x_ff;
      target_y_in           = target_y_ff;
      target_heading_in     = target_heading_ff;
      distance_gain_in      = distance_gain_ff;
      heading_gain_in       = heading_gain_ff;
      distance_tolerance_in = distance_tolerance_ff;
      heading_tolerance_in  = heading_tolerance_ff;
      goal_active_in        = goal_active_ff;
      position_reached_in   = position_reached_ff;
      rsp_valid_in          = rsp_valid_ff;
      yaw_in                = yaw_ff;
      zero_in               = zero_ff;
      dist_in               = dist_ff;
      err_in                = err_ff;
      lin_in                = lin_ff;
      res_lin_in            = res_lin_ff;
      res_ang_in            = res_ang_ff;
      res_dist_in           = res_dist_ff;
      res_status_in         = res_status_ff;
      out_lin_in            = out_lin_ff;
      out_ang_in            = out_ang_ff;
      out_dist_in           = out_dist_ff;
      out_status_in         = out_status_ff;

      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_TARGET_X:           target_x_in           = csr_data;
            REG_TARGET_Y:           target_y_in           = csr_data;
            REG_TARGET_HEADING:     target_heading_in     = csr_data[15:0];
            REG_DISTANCE_GAIN:      distance_gain_in      = csr_data[15:0];
            REG_HEADING_GAIN:       heading_gain_in       = csr_data[15:0];
            REG_DISTANCE_TOLERANCE: distance_tolerance_in = csr_data;
            REG_HEADING_TOLERANCE:  heading_tolerance_in  = csr_data[14:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (start_goal) begin
                  goal_active_in      = 1'b1;
                  position_reached_in = 1'b0;
               end else if (goal_active_ff && cancel_request) begin
                  goal_active_in = 1'b0;
                  res_lin_in     = '0;
                  res_ang_in     = '0;
                  res_dist_in    = '0;
                  res_status_in  = STATUS_CANCELED;
               end else if (goal_active_ff && pose_valid) begin
                  yaw_in  = pose_yaw;
                  zero_in = (delta_x == '0) && (delta_y == '0);
               end
            end
         end
         ST_DIST: begin
            dist_in = (|dist_sum[67:62]) ? '1 : dist_sum[61:30];
            if (dist_in < distance_tolerance_ff) begin
               position_reached_in = 1'b1;
            end
         end
         ST_ERR: begin
            if (err_raw > PI_Q13) begin
               err_in = 17'(err_raw - TWO_PI_Q13);
            end else if (err_raw < -PI_Q13) begin
               err_in = 17'(err_raw + TWO_PI_Q13);
            end else begin
               err_in = err_raw[16:0];
            end
         end
         ST_LIN: begin
            lin_in = (lin_q > 54'(LIN_MAX)) ? LIN_MAX : lin_q[13:0];
         end
         ST_ANG: begin
            res_dist_in   = dist_ff;
            res_ang_in    = ang_val;
            res_lin_in    = lin_ff;
            res_status_in = STATUS_RUNNING;
            if (position_reached_ff) begin
               res_lin_in = '0;
               if (err_abs < {2'b00, heading_tolerance_ff}) begin
                  res_ang_in     = '0;
                  res_status_in  = STATUS_SUCCEEDED;
                  goal_active_in = 1'b0;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_lin_in    = res_lin_ff;
               out_ang_in    = res_ang_ff;
               out_dist_in   = res_dist_ff;
               out_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= ST_IDLE;
         target_x_ff           <= '0;
         target_y_ff           <= '0;
         target_heading_ff     <= '0;
         distance_gain_ff      <= DISTANCE_GAIN_RST;
         heading_gain_ff       <= HEADING_GAIN_RST;
         distance_tolerance_ff <= DISTANCE_TOLERANCE_RST;
         heading_tolerance_ff  <= HEADING_TOLERANCE_RST;
         goal_active_ff        <= 1'b0;
         position_reached_ff   <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         state_ff              <= state_in;
         target_x_ff           <= target_x_in;
         target_y_ff           <= target_y_in;
         target_heading_ff     <= target_heading_in;
         distance_gain_ff      <= distance_gain_in;
         heading_gain_ff       <= heading_gain_in;
         distance_tolerance_ff <= distance_tolerance_in;
         heading_tolerance_ff  <= heading_tolerance_in;
         goal_active_ff        <= goal_active_in;
         position_reached_ff   <= position_reached_in;
         rsp_valid_ff          <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      yaw_ff        <= yaw_in;
      zero_ff       <= zero_in;
      dist_ff       <= dist_in;
      err_ff        <= err_in;
      lin_ff        <= lin_in;
      prod_ff       <= prod_in;
      res_lin_ff    <= res_lin_in;
      res_ang_ff    <= res_ang_in;
      res_dist_ff   <= res_dist_in;
      res_status_ff <= res_status_in;
      out_lin_ff    <= out_lin_in;
      out_ang_ff    <= out_ang_in;
      out_dist_ff   <= out_dist_in;
      out_status_ff <= out_status_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_dist_ff, out_ang_ff, out_lin_ff};
   assign rsp_tuser  = out_status_ff;

endmodule
`default_nettype wire

>>> rtl/gtp_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, gives the gain-scaled length and the angle.
`default_nettype none
module gtp_cordic #(
   parameter int ITERATIONS = gtp_pkg::CORDIC_ITERATIONS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [gtp_pkg::DELTA_W-1:0]   delta_x,
   input  wire logic signed [gtp_pkg::DELTA_W-1:0]   delta_y,
   output logic                                      done,
   output logic signed [gtp_pkg::CORDIC_W-1:0]       x_out,
   output logic signed [gtp_pkg::ANGLE_W-1:0]        z_out
);
   import gtp_pkg::*;

   localparam int IW = $clog2(ITERATIONS);

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   logic [IW-1:0]              count_ff, count_in;
   logic                       run_ff, run_in, done_ff, done_in;

   logic signed [CORDIC_W-1:0] x0, y0, xs, ys;

   always_comb begin
      x0 = {{(CORDIC_W-DELTA_W-16){delta_x[DELTA_W-1]}}, delta_x, 16'd0};
      y0 = {{(CORDIC_W-DELTA_W-16){delta_y[DELTA_W-1]}}, delta_y, 16'd0};
      xs = x_ff >>> count_ff;
      ys = y_ff >>> count_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         run_in   = 1'b1;
         count_in = '0;
         if (x0 < 0) begin
            if (y0 >= 0) begin
               x_in = y0;
               y_in = -x0;
               z_in = HALF_PI_Q24;
            end else begin
               x_in = -y0;
               y_in = x0;
               z_in = -HALF_PI_Q24;
            end
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (run_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_q24(ATAN_IDX_W'(count_ff));
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_q24(ATAN_IDX_W'(count_ff));
         end
         count_in = count_ff + 1'b1;
         if (count_ff == IW'(ITERATIONS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      count_ff <= count_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign z_out = z_ff;

endmodule
`default_nettype wire

>>> tb/tb_go_to_pose_p_controller.sv
// Self-checking testbench for go_to_pose_p_controller: predicts every velocity command beat.
`default_nettype none
module tb_go_to_pose_p_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import gtp_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int CORDIC_STEPS = CORDIC_ITERATIONS_DEF;
   localparam int SETTLE       = CORDIC_STEPS + 16;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASES       = 10;
   localparam int BEATS_TOTAL  = 1650;
   localparam logic [2:0] REG_UNUSED_INDEX = 3'd7;
   localparam logic signed [31:0] ONE_M = 32'sd65536;

   localparam longint ATAN_Q24 [0:31] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2,
      1, 0, 0, 0, 0, 0, 0, 0
   };

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] yaw;
      logic               valid;
      logic               cancel;
      logic               start;
   } pose_sample_type;

   typedef struct {
      logic [13:0]        lin;
      logic signed [15:0] ang;
      logic [31:0]        distance;
      goal_status_type    status;
   } velocity_command_type;

   class velocity_command_tracker;
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic signed [15:0] goal_heading;
      logic [15:0]        dist_gain;
      logic [15:0]        head_gain;
      logic [31:0]        dist_tol;
      logic [14:0]        head_tol;
      bit                 reached;
      bit                 active;
      velocity_command_type commands_due[$];
      int                 errors;
      int                 accepted_beats;

      function new();
         goal_x = '0;
         goal_y = '0;
         goal_heading = '0;
         dist_gain = DISTANCE_GAIN_RST;
         head_gain = HEADING_GAIN_RST;
         dist_tol = DISTANCE_TOLERANCE_RST;
         head_tol = HEADING_TOLERANCE_RST;
         reached = 0;
         active = 0;
         errors = 0;
         accepted_beats = 0;
      endfunction

      function int pending();
         return commands_due.size();
      endfunction

      function void write_register(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_TARGET_X:           goal_x = value;
            REG_TARGET_Y:           goal_y = value;
            REG_TARGET_HEADING:     goal_heading = value[15:0];
            REG_DISTANCE_GAIN:      dist_gain = value[15:0];
            REG_HEADING_GAIN:       head_gain = value[15:0];
            REG_DISTANCE_TOLERANCE: dist_tol = value;
            REG_HEADING_TOLERANCE:  head_tol = value[14:0];
            default: ;
         endcase
      endfunction

      function longint wrap_angle(longint e);
         while (e > PI_Q13) e -= TWO_PI_Q13;
         while (e < -longint'(PI_Q13)) e += TWO_PI_Q13;
         return e;
      endfunction

      function logic signed [15:0] turn_rate(longint e);
         longint p;
         p = (longint'(head_gain) * e + 1024) >>> 11;
         if (p > ANG_MAX) p = ANG_MAX;
         if (p < -longint'(ANG_MAX)) p = -longint'(ANG_MAX);
         return p[15:0];
      endfunction

      // Vectoring CORDIC: length and direction of (dx, dy).
      function void measure_vector(longint dx, longint dy, output logic [31:0] distance,
                                   output longint head);
         longint x, y, z, t, xs, ys;
         longint unsigned m;
         x = dx * 65536;
         y = dy * 65536;
         z = 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = HALF_PI_Q24;
            end else begin
               t = x; x = -y; y = t; z = -longint'(HALF_PI_Q24);
            end
         end
         for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys; y = y - xs; z += ATAN_Q24[i];
            end else begin
               x = x - ys; y = y + xs; z -= ATAN_Q24[i];
            end
         end
         if (x < 0) x = 0;
         m = (longint'(unsigned'(x)) + 64'd32768) >> 16;
         m = (m * 64'(INV_GAIN_Q30) + 64'd536870912) >> 30;
         if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
         distance = m[31:0];
         head = (dx == 0 && dy == 0) ? 0 : ((z + 1024) >>> 11);
      endfunction

      function void take_pose(pose_sample_type p);
         longint dx, dy, yaw, head, err, mag;
         longint unsigned lin_full;
         logic [31:0] distance;
         velocity_command_type cmd;
         accepted_beats++;
         if (p.start) begin
            active = 1;
            reached = 0;
            return;
         end
         if (!active) return;
         if (p.cancel) begin
            active = 0;
            cmd = '{lin: '0, ang: '0, distance: '0, status: STATUS_CANCELED};
            commands_due.push_back(cmd);
            return;
         end
         if (!p.valid) return;
         dx = longint'(goal_x) - longint'(p.x);
         dy = longint'(goal_y) - longint'(p.y);
         yaw = longint'(p.yaw);
         measure_vector(dx, dy, distance, head);
         if (distance < dist_tol) reached = 1;
         cmd.distance = distance;
         cmd.status = STATUS_RUNNING;
         if (!reached) begin
            err = wrap_angle(head - yaw);
            lin_full = (64'(dist_gain) * 64'(distance) + 64'd8192) >> 14;
            if (lin_full > LIN_MAX) lin_full = LIN_MAX;
            cmd.lin = lin_full[13:0];
            cmd.ang = turn_rate(err);
         end else begin
            err = wrap_angle(longint'(goal_heading) - yaw);
            mag = (err < 0) ? -err : err;
            if (mag < longint'(head_tol)) begin
               active = 0;
               cmd = '{lin: '0, ang: '0, distance: distance, status: STATUS_SUCCEEDED};
               commands_due.push_back(cmd);
               return;
            end
            cmd.lin = '0;
            cmd.ang = turn_rate(err);
         end
         commands_due.push_back(cmd);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task match_command(velocity_command_type got);
         velocity_command_type want;
         if (commands_due.size() == 0) begin
            report_mismatch($sformatf("command beat with none due (status %0d)", got.status));
            return;
         end
         want = commands_due.pop_front();
         if (got.lin !== want.lin)
            report_mismatch($sformatf("linear_velocity got %0d want %0d", got.lin, want.lin));
         if (got.ang !== want.ang)
            report_mismatch($sformatf("angular_velocity got %0d want %0d", got.ang, want.ang));
         if (got.distance !== want.distance)
            report_mismatch($sformatf("distance_feedback got %0d want %0d",
                                      got.distance, want.distance));
         if (got.status !== want.status)
            report_mismatch($sformatf("goal_status got %0d want %0d", got.status, want.status));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;   // pose_x, pose_y, pose_yaw
   logic [2:0]  req_tuser;   // pose_valid, cancel_request, start_goal
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // linear_velocity, angular_velocity, distance_feedback, zero fill
   logic [1:0]  rsp_tuser;   // goal_status
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   velocity_command_tracker tracker = new();
   pose_sample_type      seen_pose;
   velocity_command_type seen_cmd;

   int burst_left = 0;
   int hold_request = 0;
   int hold_left = 0;
   int rx_cycle = 0;
   int rx_mode = 0;
   int cycle_count = 0;
   logic signed [31:0] tgt_x = '0;
   logic signed [31:0] tgt_y = '0;
   logic signed [15:0] tgt_heading = '0;

   go_to_pose_p_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_register(csr_index, csr_data);
         if (req_tvalid && req_tready) begin
            seen_pose.x = req_tdata[31:0];
            seen_pose.y = req_tdata[63:32];
            seen_pose.yaw = req_tdata[79:64];
            seen_pose.valid = req_tuser[0];
            seen_pose.cancel = req_tuser[1];
            seen_pose.start = req_tuser[2];
            tracker.take_pose(seen_pose);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_cmd.lin = rsp_tdata[13:0];
            seen_cmd.ang = rsp_tdata[29:14];
            seen_cmd.distance = rsp_tdata[61:30];
            seen_cmd.status = goal_status_type'(rsp_tuser);
            tracker.match_command(seen_cmd);
         end
      end
   end

   // The receiver changes its stall pattern now and then and honors long hold-offs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rx_cycle++;
            if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (rx_cycle % 8 < 5);
            endcase
         end
      end
   end

   function automatic logic [31:0] random_offset(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic logic [15:0] any_yaw();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 51472) - 25736);
   endfunction

   task automatic tick(logic signed [31:0] x, logic signed [31:0] y, logic signed [15:0] yaw,
                       logic valid, logic cancel, logic start);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {yaw, y, x};
      req_tuser  <= {start, cancel, valid};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_profile(int p);
      logic [31:0] tx, ty, dtol;
      logic [15:0] th, dg, hg;
      logic [14:0] htol;
      case (p)
         0: begin
            tx = '0; ty = '0; th = '0;
            dg = DISTANCE_GAIN_RST; hg = HEADING_GAIN_RST;
            dtol = DISTANCE_TOLERANCE_RST; htol = HEADING_TOLERANCE_RST;
         end
         2: begin
            tx = 32'h7FFF_FFFF; ty = 32'h8000_0000; th = 16'd25736;
            dg = 16'hFFFF; hg = 16'hFFFF; dtol = 32'hFFFF_FFFF; htol = 15'd25736;
         end
         3: begin
            tx = 32'h8000_0000; ty = 32'h7FFF_FFFF; th = -16'sd25736;
            dg = '0; hg = '0; dtol = '0; htol = '0;
         end
         default: begin
            tx = random_offset(1000000);
            ty = random_offset(1000000);
            th = 16'(random_offset(25736));
            dg = 16'($urandom_range(500, 8000));
            hg = 16'($urandom_range(1000, 20000));
            dtol = $urandom_range(2000, 60000);
            htol = 15'($urandom_range(100, 2000));
            if (p >= 4) begin
               if ($urandom_range(0, 2) == 0) tx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               if ($urandom_range(0, 2) == 0) ty = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               if ($urandom_range(0, 2) == 0) th = $urandom_range(0, 1) ? 16'd25736 : -16'sd25736;
               if ($urandom_range(0, 2) == 0) dg = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               if ($urandom_range(0, 2) == 0) hg = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               if ($urandom_range(0, 3) == 0) dtol = $urandom_range(0, 1) ? 32'hFFFF_FFFF : '0;
               if ($urandom_range(0, 3) == 0) htol = $urandom_range(0, 1) ? 15'd25736 : '0;
            end
         end
      endcase
      tgt_x = tx;
      tgt_y = ty;
      tgt_heading = th;
      write_register(REG_TARGET_X, tx);
      write_register(REG_TARGET_Y, ty);
      write_register(REG_TARGET_HEADING, {16'h0000, th});
      write_register(REG_DISTANCE_GAIN, {16'h0000, dg});
      write_register(REG_HEADING_GAIN, {16'h0000, hg});
      write_register(REG_DISTANCE_TOLERANCE, dtol);
      write_register(REG_HEADING_TOLERANCE, {17'h00000, htol});
      write_register(REG_UNUSED_INDEX, $urandom);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One goal: start, far approach, arrival, then turning toward the goal heading; a random cancel may end it early.
   task automatic run_goal();
      int n, r;
      tick($urandom, $urandom, 16'($urandom), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)), 1'b1);
      n = $urandom_range(0, 5);
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            tick($urandom, $urandom, 16'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b0);
            return;
         end else if (r < 10) begin
            tick($urandom, $urandom, 16'($urandom), 1'b0, 1'b0, 1'b0);
         end else if (r < 15) begin
            tick($urandom, $urandom, any_yaw(), 1'b1, 1'b0, 1'b0);
         end else begin
            tick(tgt_x - random_offset(2097152), tgt_y - random_offset(2097152), any_yaw(),
                 1'b1, 1'b0, 1'b0);
         end
      end
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++)
         tick(tgt_x - random_offset(3000), tgt_y - random_offset(3000), any_yaw(),
              1'b1, 1'b0, 1'b0);
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            tick($urandom, $urandom, 16'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b0);
            return;
         end
         tick(tgt_x - random_offset((r < 70) ? 3000 : 2097152),
              tgt_y - random_offset((r < 70) ? 3000 : 2097152),
              ($urandom_range(0, 99) < 65) ? 16'(tgt_heading + random_offset(600))
                                           : any_yaw(),
              1'b1, 1'b0, 1'b0);
      end
   endtask

   task automatic directed_checks();
      tick(ONE_M, 0, 0, 1'b1, 1'b0, 1'b0);
      tick(0, 0, 0, 1'b1, 1'b1, 1'b0);
      tick(ONE_M, ONE_M, 0, 1'b1, 1'b1, 1'b1);
      tick(32'h8000_0000, 32'h7FFF_FFFF, 16'sd25736, 1'b1, 1'b0, 1'b0);
      tick(32'h7FFF_FFFF, 32'h8000_0000, -16'sd25736, 1'b1, 1'b0, 1'b0);
      tick(ONE_M, 0, 0, 1'b1, 1'b0, 1'b0);
      tick(ONE_M, ONE_M, 16'sh7FFF, 1'b1, 1'b0, 1'b0);
      tick(-ONE_M, -ONE_M, 16'sh8000, 1'b1, 1'b0, 1'b0);
      tick(0, -2 * ONE_M, 0, 1'b0, 1'b0, 1'b0);
      tick(-ONE_M, 0, 16'sd12000, 1'b1, 1'b0, 1'b0);
      tick(0, 0, 16'sd8000, 1'b1, 1'b0, 1'b0);
      tick(5 * ONE_M, -ONE_M, -16'sd8000, 1'b1, 1'b0, 1'b0);
      tick(100, -100, 0, 1'b1, 1'b0, 1'b0);
      tick(0, 0, 0, 1'b1, 1'b0, 1'b0);
      tick(0, 0, 0, 1'b0, 1'b0, 1'b1);
      tick(-3 * ONE_M, 2 * ONE_M, 16'sd1000, 1'b1, 1'b0, 1'b0);
      tick(0, 0, 0, 1'b0, 1'b1, 1'b0);
      tick(0, 0, 0, 1'b1, 1'b1, 1'b0);
      tick(ONE_M, 0, 0, 1'b0, 1'b0, 1'b1);
      tick(ONE_M, 0, 0, 1'b1, 1'b0, 1'b1);
      tick(0, 0, -16'sd409, 1'b1, 1'b0, 1'b0);
      tick(0, 0, 0, 1'b1, 1'b0, 1'b1);
      tick(0, 0, 16'sd410, 1'b1, 1'b0, 1'b0);
      tick(0, 0, 0, 1'b1, 1'b1, 1'b0);
   endtask

   initial begin
      int phase_goal;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_checks();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      phase_goal = tracker.accepted_beats;
      for (int p = 0; p < PHASES; p++) begin
         apply_profile(p);
         if (p == 0) begin
            // Hold the result side off while poses keep coming, so the input stalls.
            hold_request = 300;
            tick(0, 0, 0, 1'b1, 1'b0, 1'b1);
            for (int k = 0; k < 40; k++)
               tick(random_offset(2097152) | 32'h0010_0000, random_offset(2097152), any_yaw(),
                    1'b1, 1'b0, 1'b0);
            wait_drained();
         end
         phase_goal += BEATS_TOTAL / PHASES;
         while (tracker.accepted_beats < phase_goal) begin
            if ($urandom_range(0, 99) < 85) begin
               run_goal();
            end else begin
               repeat ($urandom_range(1, 3))
                  tick($urandom, $urandom, 16'($urandom), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
            end
         end
         wait_drained();
         repeat (SETTLE) @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
rtl/gtp_pkg.sv
rtl/gtp_cordic.sv
rtl/go_to_pose_p_controller.sv
tb/tb_go_to_pose_p_controller.sv
